// ===== hw/rtl/spp_pkg.sv =====
`timescale 1ns / 1ps

package spp_pkg;

  // Fixed field widths of the word formats.
  localparam int LEVEL_W = 32;
  localparam int BIN_W   = 10;
  localparam int TOP_W   = 4;
  localparam int RANK_W  = 3;

  // The bin index saturates at the top of its field.
  localparam logic [BIN_W-1:0] BIN_MAX = {BIN_W{1'b1}};

  // Register reset value and default list depth.
  localparam logic [TOP_W-1:0] TOP_COUNT_RESET = TOP_W'(5);
  localparam int               MAX_PEAKS_DEF   = 8;

  // One entry of the ranked list.
  typedef struct packed {
    logic               valid;
    logic [LEVEL_W-1:0] level;
    logic [BIN_W-1:0]   bin;
  } slot_t;

  localparam slot_t EMPTY_SLOT = '0;

  // Per-cell control from the top level.
  typedef struct packed {
    logic clear;   // drop the entry at the end of a frame
    logic shift;   // take the right neighbor's entry while reporting
    logic insert;  // a peak is offered and this cell lies inside the count
  } cell_ctl_t;

endpackage

// ===== hw/rtl/spp_cell.sv =====
`timescale 1ns / 1ps

module spp_cell
  import spp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cell_ctl_t          ctl,
  input  logic [LEVEL_W-1:0] lvl_new,
  input  logic [BIN_W-1:0]   bin_new,
  input  slot_t              left,
  input  logic               left_beats,
  input  slot_t              right,
  output slot_t              slot,
  output logic               beats
);

  logic               valid;
  logic [LEVEL_W-1:0] level;
  logic [BIN_W-1:0]   bin;

  // The offered peak outranks this entry; an empty entry is lowest.
  assign beats = !valid || (lvl_new > level);

  assign slot = '{valid: valid, level: level, bin: bin};

  // The valid bit is control state and clears at reset.
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      valid <= 1'b0;
    end else if (ctl.shift) begin
      valid <= right.valid;
    end else if (ctl.insert && beats) begin
      valid <= left_beats ? left.valid : 1'b1;
    end
  end

  // Payload: shift toward the head while reporting, otherwise insert.
  // When the left neighbor is also beaten the entry moves down one place;
  // the first beaten cell takes the new peak.
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      level <= right.level;
      bin   <= right.bin;
    end else if (ctl.insert && beats) begin
      if (left_beats) begin
        level <= left.level;
        bin   <= left.bin;
      end else begin
        level <= lvl_new;
        bin   <= bin_new;
      end
    end
  end

endmodule

// ===== hw/rtl/spectral_top_peak_picker_top.sv =====
`timescale 1ns / 1ps

// Top-N spectral peak picker.
// Input words carry one magnitude bin each, DC first, with last_bin set on
// the bin that ends the frame. A bin strictly above both neighbors (never the
// first or last bin of a frame) is offered to a ranked list held in a row of
// MAX_PEAKS cells; all cells compare and shift in parallel, so one input word
// is taken per cycle while a frame streams in.
// When the last bin is accepted, the frame's list is reported starting on
// the next cycle: min(top_count, MAX_PEAKS) output words, one per cycle when
// the receiver does not stall, rank 0 first, empty slots with slot_valid low
// and run_end on the final word. The row shifts toward its head on each
// accepted output word. Input is stalled while the report is in progress,
// including while the receiver stalls. With a count of zero nothing is
// reported and no stall occurs. A stall on the output holds the current word
// unchanged.
// top_count is written through cfg_wr_en / cfg_wr_data while the block is
// idle; the user must keep to this, the block itself does not enforce it. Reset
// (rst, synchronous) sets top_count to 5, empties the list and clears the bin history and index.

module spectral_top_peak_picker_top
  import spp_pkg::*;
#(
  parameter int MAX_PEAKS = MAX_PEAKS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [TOP_W-1:0]   cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [LEVEL_W-1:0] magnitude,
  input  logic               last_bin,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [RANK_W-1:0]  rank,
  output logic [BIN_W-1:0]   peak_bin,
  output logic [LEVEL_W-1:0] peak_level,
  output logic               slot_valid,
  output logic               run_end
);

  localparam int CNT_MIN = $clog2(MAX_PEAKS + 1);
  localparam int CNT_W   = (CNT_MIN > TOP_W) ? CNT_MIN : TOP_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PEAKS);

  typedef enum logic {
    ST_COLLECT,
    ST_REPORT
  } state_t;

  state_t             state;
  logic [TOP_W-1:0]   top_count;
  logic [BIN_W-1:0]   bin_counter;
  logic [LEVEL_W-1:0] older_level;
  logic [LEVEL_W-1:0] newer_level;
  logic [CNT_W-1:0]   emit_idx;
  logic [CNT_W-1:0]   emit_cnt;

  logic [CNT_W-1:0]   count_ext;
  logic [CNT_W-1:0]   active_cnt;
  logic               in_take;
  logic               out_take;
  logic               is_peak;
  logic               peak_ok;
  logic               emit_last;
  logic [BIN_W-1:0]   peak_idx;

  slot_t              cell_slot [MAX_PEAKS];
  logic [MAX_PEAKS-1:0] cell_beats;
  logic [MAX_PEAKS-1:0] cell_tail;
  logic [MAX_PEAKS-1:0] cell_active;
  logic [MAX_PEAKS-1:0] cell_valid;

  // Effective count saturates at the list depth.
  assign count_ext  = CNT_W'(top_count);
  assign active_cnt = (count_ext > CNT_MAX) ? CNT_MAX : count_ext;

  assign in_stall = (state == ST_REPORT);
  assign out_valid = (state == ST_REPORT);
  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  // The previous bin is a peak once both of its neighbors are known.
  assign is_peak  = (bin_counter >= BIN_W'(2)) && (newer_level > older_level) &&
                    (newer_level > magnitude);
  assign peak_idx = bin_counter - BIN_W'(1);

  // The peak enters only if it beats the tail slot of the active count.
  assign peak_ok = in_take && is_peak && (active_cnt != '0) &&
                   (|(cell_beats & cell_tail));

  assign emit_last = (emit_idx == emit_cnt - CNT_W'(1));

  // Row of list cells, head at index zero.
  for (genvar i = 0; i < MAX_PEAKS; i++) begin : g_cell
    slot_t     left_s;
    slot_t     right_s;
    logic      left_b;
    cell_ctl_t ctl;

    if (i == 0) begin : g_head
      assign left_s = EMPTY_SLOT;
      assign left_b = 1'b0;
    end else begin : g_body
      assign left_s = cell_slot[i-1];
      assign left_b = cell_beats[i-1];
    end

    if (i == MAX_PEAKS - 1) begin : g_tail
      assign right_s = EMPTY_SLOT;
    end else begin : g_inner
      assign right_s = cell_slot[i+1];
    end

    assign cell_tail[i]   = (active_cnt == CNT_W'(i + 1));
    assign cell_active[i] = (CNT_W'(i) < active_cnt);
    assign cell_valid[i]  = cell_slot[i].valid;

    // Frame end clears the row, either after the report or at once for
    // a count of zero.
    assign ctl.clear  = (out_take && emit_last) ||
                        (in_take && last_bin && (active_cnt == '0));
    assign ctl.shift  = out_take;
    assign ctl.insert = peak_ok && cell_active[i];

    spp_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .lvl_new    (newer_level),
      .bin_new    (peak_idx),
      .left       (left_s),
      .left_beats (left_b),
      .right      (right_s),
      .slot       (cell_slot[i]),
      .beats      (cell_beats[i])
    );
  end

  // Output word is read from the head cell.
  assign rank       = emit_idx[RANK_W-1:0];
  assign slot_valid = cell_slot[0].valid;
  assign peak_bin   = cell_slot[0].valid ? cell_slot[0].bin : '0;
  assign peak_level = cell_slot[0].valid ? cell_slot[0].level : '0;
  assign run_end    = emit_last;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      top_count <= TOP_COUNT_RESET;
    end else if (cfg_wr_en) begin
      top_count <= cfg_wr_data;
    end
  end

  // Frame sequencer and bin history.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_COLLECT;
      bin_counter <= '0;
      older_level <= '0;
      newer_level <= '0;
      emit_idx    <= '0;
      emit_cnt    <= '0;
    end else begin
      case (state)
        ST_COLLECT: begin
          if (in_take) begin
            if (last_bin) begin
              bin_counter <= '0;
              older_level <= '0;
              newer_level <= '0;
              emit_idx    <= '0;
              emit_cnt    <= active_cnt;
              if (active_cnt != '0) begin
                state <= ST_REPORT;
              end
            end else begin
              older_level <= newer_level;
              newer_level <= magnitude;
              if (bin_counter != BIN_MAX) begin
                bin_counter <= bin_counter + BIN_W'(1);
              end
            end
          end
        end
        ST_REPORT: begin
          if (out_take) begin
            if (emit_last) begin
              state <= ST_COLLECT;
            end else begin
              emit_idx <= emit_idx + CNT_W'(1);
            end
          end
        end
        default: begin
          state <= ST_COLLECT;
        end
      endcase
    end
  end

  // The report index stays inside the latched count.
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (emit_idx < emit_cnt))
    else $error("report index beyond count");

  // A frame end with a nonzero count starts the report at rank zero.
  a_report_start: assert property (@(posedge clk) disable iff (rst)
    (in_take && last_bin && (active_cnt != '0)) |=> (out_valid && (emit_idx == '0)))
    else $error("report did not start at rank zero");

  // Taking the final word ends the report and empties the row.
  a_report_end: assert property (@(posedge clk) disable iff (rst)
    (out_take && emit_last) |=> (!out_valid && (cell_valid == '0)))
    else $error("list not cleared after report");

  // Outside a report, an empty slot is never followed by a filled one.
  a_list_packed: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> ((cell_valid & ~(cell_valid >> 1) & (cell_valid >> 1)) == '0 &&
                    (((cell_valid >> 1) & ~cell_valid) == '0)))
    else $error("list has a gap");

endmodule
